[rtl/core/lvwm_pkg.sv]
// ----------------------------------------------------------------------------
// lvwm_pkg
// Shared types and constants of the line voltage window monitor.
// ----------------------------------------------------------------------------
package lvwm_pkg;

    localparam int LVWM_WINDOW   = 8;
    localparam int LVWM_SAMPLE_W = 16;
    localparam int LVWM_CFG_IDX_W = 3;

    typedef enum logic [LVWM_CFG_IDX_W-1:0] {
        CFG_SPIKE_MARGIN    = 3'd0,
        CFG_OVERFLOW_LIMIT  = 3'd1,
        CFG_UNDERFLOW_LIMIT = 3'd2,
        CFG_BASELINE_PRESET = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RANGE_OK    = 2'd0,
        RANGE_OVER  = 2'd1,
        RANGE_UNDER = 2'd2
    } t_range;

    typedef struct packed {
        logic [LVWM_SAMPLE_W-1:0] spike_margin;
        logic [LVWM_SAMPLE_W-1:0] overflow_limit;
        logic [LVWM_SAMPLE_W-1:0] underflow_limit;
    } t_limits;

    typedef struct packed {
        logic                     load;
        logic [LVWM_SAMPLE_W-1:0] value;
    } t_bl_load;

endpackage

[rtl/core/line_voltage_window_monitor.sv]
// ----------------------------------------------------------------------------
// line_voltage_window_monitor
// Moving-average monitor of raw ADC line-voltage samples with spike and
// over/under-range checks against programmable limits.
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_ready  i_sample, i_capture_baseline
//   out      output     o_out_valid / i_out_ready o_mean_level, o_spike,
//                                                o_range_status
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; a result passes
// through ring read, sum update, reciprocal multiply and checks, each registered.
// The ring memory has one read and one write port, each used once per word.
// Reset is synchronous; it empties the pipeline and marks every ring entry
// as zero through per-entry valid bits, so no clearing pass is needed.
// A stalled output holds each stage; the input stays open while any stage
// ahead of it can move.
// ----------------------------------------------------------------------------
module line_voltage_window_monitor
    import lvwm_pkg::*;
#(
    parameter int WINDOW = LVWM_WINDOW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LVWM_SAMPLE_W-1:0]  i_sample,
    input  logic                      i_capture_baseline,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LVWM_SAMPLE_W-1:0]  o_mean_level,
    output logic                      o_spike,
    output logic [1:0]                o_range_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [LVWM_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LVWM_SAMPLE_W-1:0]  i_cfg_data
);

    localparam int SUM_W = LVWM_SAMPLE_W + $clog2(WINDOW);

    t_limits                  r_lim;
    t_bl_load                 bl_load;
    logic                     cfg_wr;
    logic                     in_acc;
    logic                     a_en;
    logic                     b_en;
    logic                     c_en;
    logic                     d_en;
    logic                     b_vld;
    logic [SUM_W-1:0]         b_sum;
    logic                     b_cap;
    logic                     c_vld;
    logic [LVWM_SAMPLE_W-1:0] c_mean;
    logic                     c_cap;
    logic                     d_vld;
    t_range                   d_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.spike_margin    <= '0;
            r_lim.overflow_limit  <= '1;
            r_lim.underflow_limit <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SPIKE_MARGIN:    r_lim.spike_margin    <= i_cfg_data;
                CFG_OVERFLOW_LIMIT:  r_lim.overflow_limit  <= i_cfg_data;
                CFG_UNDERFLOW_LIMIT: r_lim.underflow_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign bl_load.load  = cfg_wr && (i_cfg_index == CFG_BASELINE_PRESET);
    assign bl_load.value = i_cfg_data;

    assign d_en       = !d_vld || i_out_ready;
    assign c_en       = !c_vld || d_en;
    assign b_en       = !b_vld || c_en;
    assign o_in_ready = a_en;
    assign in_acc     = i_in_valid && a_en;

    lvwm_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_sample(i_sample),
        .i_cap   (i_capture_baseline),
        .i_b_en  (b_en),
        .o_a_en  (a_en),
        .o_b_vld (b_vld),
        .o_b_sum (b_sum),
        .o_b_cap (b_cap)
    );

    lvwm_mean_div #(
        .WINDOW (WINDOW)
    ) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_vld   (b_vld),
        .i_sum   (b_sum),
        .i_cap   (b_cap),
        .o_vld   (c_vld),
        .o_mean  (c_mean),
        .o_cap   (c_cap)
    );

    lvwm_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (d_en),
        .i_vld   (c_vld),
        .i_mean  (c_mean),
        .i_cap   (c_cap),
        .i_lim   (r_lim),
        .i_bl    (bl_load),
        .o_vld   (d_vld),
        .o_mean  (o_mean_level),
        .o_spike (o_spike),
        .o_status(d_status)
    );

    assign o_out_valid    = d_vld;
    assign o_range_status = d_status;

    a_spike_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_spike |-> o_mean_level != '0)
        else $error("spike flagged on zero mean");

    a_over_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_status == RANGE_OVER |-> o_mean_level > r_lim.overflow_limit)
        else $error("over-range status without mean above limit");

    a_under_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_status == RANGE_UNDER
            |-> o_mean_level < r_lim.underflow_limit)
        else $error("under-range status without mean below limit");

endmodule

[rtl/core/lvwm_window.sv]
// ----------------------------------------------------------------------------
// lvwm_window
// Sample ring memory with running window sum. Reads the oldest sample in the
// accept cycle, then subtracts it, adds the new sample and writes it back.
// ----------------------------------------------------------------------------
module lvwm_window
    import lvwm_pkg::*;
#(
    parameter int WINDOW = LVWM_WINDOW
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_acc,
    input  logic [LVWM_SAMPLE_W-1:0]                   i_sample,
    input  logic                                       i_cap,
    input  logic                                       i_b_en,
    output logic                                       o_a_en,
    output logic                                       o_b_vld,
    output logic [LVWM_SAMPLE_W+$clog2(WINDOW)-1:0]    o_b_sum,
    output logic                                       o_b_cap
);

    localparam int PW    = $clog2(WINDOW);
    localparam int SUM_W = LVWM_SAMPLE_W + PW;

    logic [LVWM_SAMPLE_W-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0]        r_vld_bits;
    logic [PW-1:0]            r_wr_ptr;

    logic                     r_a_vld;
    logic [LVWM_SAMPLE_W-1:0] r_a_sample;
    logic                     r_a_cap;
    logic [PW-1:0]            r_a_ptr;
    logic [LVWM_SAMPLE_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic                     r_b_vld;
    logic                     r_b_cap;
    logic                     a_adv;
    logic [LVWM_SAMPLE_W-1:0] old_sample;

    assign o_a_en     = !r_a_vld || i_b_en;
    assign a_adv      = r_a_vld && i_b_en;
    assign old_sample = r_rd_vld ? r_rd_data : '0;
    assign n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_a_sample);

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_mem[r_a_ptr] <= r_a_sample;
        end
        if (i_acc) begin
            r_rd_data <= r_mem[r_wr_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
            r_wr_ptr   <= '0;
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_sum      <= '0;
        end else begin
            if (a_adv) begin
                r_vld_bits[r_a_ptr] <= 1'b1;
                r_sum               <= n_sum;
            end
            if (i_acc) begin
                r_wr_ptr <= (r_wr_ptr == PW'(WINDOW - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (o_a_en) begin
                r_a_vld <= i_acc;
            end
            if (i_b_en) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_a_sample <= i_sample;
            r_a_cap    <= i_cap;
            r_a_ptr    <= r_wr_ptr;
            r_rd_vld   <= r_vld_bits[r_wr_ptr];
        end
        if (a_adv) begin
            r_b_cap <= r_a_cap;
        end
    end

    assign o_b_vld = r_b_vld;
    assign o_b_sum = r_sum;
    assign o_b_cap = r_b_cap;

endmodule

[rtl/core/lvwm_mean_div.sv]
// ----------------------------------------------------------------------------
// lvwm_mean_div
// Divides the window sum by WINDOW through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module lvwm_mean_div
    import lvwm_pkg::*;
#(
    parameter int WINDOW = LVWM_WINDOW
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_vld,
    input  logic [LVWM_SAMPLE_W+$clog2(WINDOW)-1:0]  i_sum,
    input  logic                                     i_cap,
    output logic                                     o_vld,
    output logic [LVWM_SAMPLE_W-1:0]                 o_mean,
    output logic                                     o_cap
);

    localparam int          PW     = $clog2(WINDOW);
    localparam int          SUM_W  = LVWM_SAMPLE_W + PW;
    localparam int          SHIFT  = SUM_W + PW;
    localparam int          RCP_W  = SUM_W + 1;
    localparam int          PROD_W = SUM_W + RCP_W;
    localparam logic [63:0] RCP    = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    logic              r_vld;
    logic              r_cap;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(RCP[RCP_W-1:0]);
            r_cap  <= i_cap;
        end
    end

    assign o_vld  = r_vld;
    assign o_mean = r_prod[SHIFT +: LVWM_SAMPLE_W];
    assign o_cap  = r_cap;

endmodule

[rtl/core/lvwm_check.sv]
// ----------------------------------------------------------------------------
// lvwm_check
// Spike and range checks on the mean, baseline capture and output register.
// ----------------------------------------------------------------------------
module lvwm_check
    import lvwm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [LVWM_SAMPLE_W-1:0] i_mean,
    input  logic                     i_cap,
    input  t_limits                  i_lim,
    input  t_bl_load                 i_bl,
    output logic                     o_vld,
    output logic [LVWM_SAMPLE_W-1:0] o_mean,
    output logic                     o_spike,
    output t_range                   o_status
);

    logic                     r_vld;
    logic [LVWM_SAMPLE_W-1:0] r_baseline;
    logic [LVWM_SAMPLE_W-1:0] r_mean;
    logic                     r_spike;
    t_range                   r_status;
    logic [LVWM_SAMPLE_W:0]   thresh;
    logic                     spike;
    t_range                   status;
    logic                     take;

    assign take   = i_en && i_vld;
    assign thresh = {1'b0, r_baseline} + {1'b0, i_lim.spike_margin};
    assign spike  = {1'b0, i_mean} > thresh;

    always_comb begin
        priority if (i_mean > i_lim.overflow_limit) begin
            status = RANGE_OVER;
        end else if (i_mean < i_lim.underflow_limit) begin
            status = RANGE_UNDER;
        end else begin
            status = RANGE_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_baseline <= '0;
        end else begin
            if (i_en) begin
                r_vld <= i_vld;
            end
            if (i_bl.load) begin
                r_baseline <= i_bl.value;
            end else if (take && i_cap) begin
                r_baseline <= i_mean;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mean   <= i_mean;
            r_spike  <= spike;
            r_status <= status;
        end
    end

    assign o_vld    = r_vld;
    assign o_mean   = r_mean;
    assign o_spike  = r_spike;
    assign o_status = r_status;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the line voltage window monitor. A scoreboard class keeps its
// own sample ring, running sum, baseline and limit registers, predicts mean,
// spike and range status for every accepted word and checks each output word
// in order. Directed words cover the field extremes, the capture timing, a
// spike threshold above full scale and crossed limits; random phases follow
// with fresh register settings, random idling on both sides, a phase with no
// idling, a long output hold-off and a mid-phase drain of the sender.
// ----------------------------------------------------------------------------
module tb
    import lvwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY  = 3;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 2;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 36;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_WORDS   = 280;

    typedef struct {
        logic [LVWM_SAMPLE_W-1:0] mean;
        logic                     spike;
        t_range                   status;
    } t_window_reading;

    class window_mean_board;
        logic [LVWM_SAMPLE_W-1:0] ring [LVWM_WINDOW];
        int unsigned              wr_pos;
        logic [21:0]              running_sum;
        logic [LVWM_SAMPLE_W-1:0] baseline;
        logic [LVWM_SAMPLE_W-1:0] spike_margin;
        logic [LVWM_SAMPLE_W-1:0] overflow_limit;
        logic [LVWM_SAMPLE_W-1:0] underflow_limit;
        t_window_reading          expected_readings [$];
        int unsigned              fails;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_pos          = 0;
            running_sum     = '0;
            baseline        = '0;
            spike_margin    = '0;
            overflow_limit  = '1;
            underflow_limit = '0;
            fails           = 0;
        endfunction

        function void set_reg(logic [LVWM_CFG_IDX_W-1:0] idx, logic [LVWM_SAMPLE_W-1:0] value);
            case (idx)
                CFG_SPIKE_MARGIN:    spike_margin = value;
                CFG_OVERFLOW_LIMIT:  overflow_limit = value;
                CFG_UNDERFLOW_LIMIT: underflow_limit = value;
                CFG_BASELINE_PRESET: baseline = value;
                default: ;
            endcase
        endfunction

        function void take_sample(logic [LVWM_SAMPLE_W-1:0] sample, logic capture);
            t_window_reading r;
            logic [16:0]     threshold;
            running_sum = running_sum - 22'(ring[wr_pos]) + 22'(sample);
            ring[wr_pos] = sample;
            wr_pos = (wr_pos + 1) % LVWM_WINDOW;
            r.mean = LVWM_SAMPLE_W'(running_sum / LVWM_WINDOW);
            threshold = {1'b0, baseline} + {1'b0, spike_margin};
            r.spike = ({1'b0, r.mean} > threshold);
            if (r.mean > overflow_limit) begin
                r.status = RANGE_OVER;
            end else if (r.mean < underflow_limit) begin
                r.status = RANGE_UNDER;
            end else begin
                r.status = RANGE_OK;
            end
            if (capture) begin
                baseline = r.mean;
            end
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic [LVWM_SAMPLE_W-1:0] mean, logic spike,
                                    logic [1:0] status);
            t_window_reading e;
            if (expected_readings.size() == 0) begin
                $error("unexpected output word: mean_level %0d spike %0d range_status %0d",
                       mean, spike, status);
                fails++;
                return;
            end
            e = expected_readings.pop_front();
            if (e.mean !== mean) begin
                $error("mean_level: expected %0d, actual %0d", e.mean, mean);
                fails++;
            end
            if (e.spike !== spike) begin
                $error("spike: expected %0d, actual %0d", e.spike, spike);
                fails++;
            end
            if (e.status !== status) begin
                $error("range_status: expected %0d, actual %0d", e.status, status);
                fails++;
            end
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [LVWM_SAMPLE_W-1:0]  i_sample;
    logic                      i_capture_baseline;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [LVWM_SAMPLE_W-1:0]  o_mean_level;
    logic                      o_spike;
    logic [1:0]                o_range_status;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [LVWM_CFG_IDX_W-1:0] i_cfg_index;
    logic [LVWM_SAMPLE_W-1:0]  i_cfg_data;

    window_mean_board sb;
    bit               idle_en;
    bit               hold_req;

    line_voltage_window_monitor i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_reading(o_mean_level, o_spike, o_range_status);
        end
    end

    task automatic send_sample(logic [LVWM_SAMPLE_W-1:0] sample, logic capture);
        int gap;
        gap = 0;
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_sample           <= sample;
        i_capture_baseline <= capture;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_sample(sample, capture);
    endtask

    task automatic write_reg(logic [LVWM_CFG_IDX_W-1:0] idx, logic [LVWM_SAMPLE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, drain the pipeline, then let it settle
    task automatic wait_idle();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LVWM_SAMPLE_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return LVWM_SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [LVWM_SAMPLE_W-1:0] pick_sample(int level, int spread);
        int v;
        case ($urandom_range(0, 19))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return LVWM_SAMPLE_W'($urandom);
            default: begin
                v = level + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return LVWM_SAMPLE_W'(v);
            end
        endcase
    endfunction

    initial begin
        int level;
        int spread;
        logic [LVWM_SAMPLE_W-1:0] margin;
        sb                  = new();
        idle_en             = 1'b1;
        hold_req            = 1'b0;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_sample           <= '0;
        i_capture_baseline <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= CFG_SPIKE_MARGIN;
        i_cfg_data         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ramp to full scale, capture, then flush with zeros
        repeat (8) send_sample('1, 1'b0);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);
        repeat (8) send_sample('0, 1'b0);
        wait_idle();

        // threshold above full scale, crossed limits, unused index
        write_reg(CFG_SPIKE_MARGIN, '1);
        write_reg(CFG_BASELINE_PRESET, '1);
        write_reg(CFG_OVERFLOW_LIMIT, '0);
        write_reg(CFG_UNDERFLOW_LIMIT, '1);
        write_reg(LVWM_CFG_IDX_W'($urandom_range(2 ** LVWM_CFG_IDX_W - 1,
                                                 int'(CFG_BASELINE_PRESET) + 1)),
                  LVWM_SAMPLE_W'($urandom));
        repeat (3) send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        repeat (3) send_sample('1, 1'b0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       margin = '0;
                1:       margin = '1;
                2:       margin = LVWM_SAMPLE_W'($urandom_range(0, 1024));
                default: margin = LVWM_SAMPLE_W'($urandom);
            endcase
            write_reg(CFG_SPIKE_MARGIN, margin);
            write_reg(CFG_OVERFLOW_LIMIT, pick_limit());
            write_reg(CFG_UNDERFLOW_LIMIT, pick_limit());
            write_reg(CFG_BASELINE_PRESET, pick_limit());
            write_reg(LVWM_CFG_IDX_W'($urandom_range(2 ** LVWM_CFG_IDX_W - 1,
                                                     int'(CFG_BASELINE_PRESET) + 1)),
                      LVWM_SAMPLE_W'($urandom));
            idle_en = (p != 2);
            level   = $urandom_range(0, 65535);
            spread  = $urandom_range(0, 4095);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 3 && i == 40) begin
                    hold_req = 1'b1;
                end
                if (p == 4 && i == 140) begin
                    wait_idle();
                end
                send_sample(pick_sample(level, spread), $urandom_range(0, 9) == 0);
            end
            wait_idle();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected output words never arrived", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[line_voltage_window_monitor.f]
rtl/core/lvwm_pkg.sv
rtl/core/lvwm_window.sv
rtl/core/lvwm_mean_div.sv
rtl/core/lvwm_check.sv
rtl/core/line_voltage_window_monitor.sv
dv/tb.sv
